>>> hdl/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg: shared types and constants of the Laplacian edge filter
// Pixel and sum widths, register indexes, kernel weights and the kernel
// selection helpers used by the window cells and the filter top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lef_pkg;

	localparam int PIX_W   = 8;
	localparam int SUM_W   = 11;
	localparam int WSUM_W  = 14;
	localparam int RESP_W  = 15;
	localparam int FW_W    = 12;
	localparam int FH_W    = 16;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 16;
	localparam int CCOL_W  = 11;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_3X3 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_5X5 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_7X7 = 2'd2;

	localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
	localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 16'd480;
	localparam logic [MODE_W-1:0] RST_KERNEL_MODE  = MODE_3X3;

	localparam int W_CROSS = 4;
	localparam int W_5     = 24;
	localparam int W_7     = 48;
	localparam int PIX_MAX = 255;

	typedef enum logic [1:0] {
		KS_3,
		KS_5,
		KS_7
	} ksel_t;

	function automatic ksel_t kernel_sel(input logic [MODE_W-1:0] mode, input int max_k);
		ksel_t k;
		case (mode)
			MODE_5X5: k = KS_5;
			MODE_7X7: k = KS_7;
			default:  k = KS_3;
		endcase
		if (k == KS_7 && max_k < 7) begin
			k = (max_k >= 5) ? KS_5 : KS_3;
		end
		if (k == KS_5 && max_k < 5) begin
			k = KS_3;
		end
		return k;
	endfunction

	function automatic int kernel_half(input ksel_t k);
		int h;
		case (k)
			KS_5:    h = 2;
			KS_7:    h = 3;
			default: h = 1;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

>>> hdl/lef_ram.sv
// ----------------------------------------------------------------------------
// lef_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/lef_cell.sv
// ----------------------------------------------------------------------------
// lef_cell: one column cell of the filter window
// Holds one window column and its partial column sums, and takes over the
// column of its right-hand neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_cell #(
	parameter int ROWS = 7
) (
	input  wire logic                                     clk,
	input  wire logic                                     shift,
	input  wire logic [ROWS-1:0][lef_pkg::PIX_W-1:0]      pix_in,
	input  wire logic [lef_pkg::SUM_W-1:0]                lo_in,
	input  wire logic [lef_pkg::SUM_W-1:0]                hi_in,
	output logic      [ROWS-1:0][lef_pkg::PIX_W-1:0]      pix_out,
	output logic      [lef_pkg::SUM_W-1:0]                lo_out,
	output logic      [lef_pkg::SUM_W-1:0]                hi_out
);

	import lef_pkg::*;

	logic [ROWS-1:0][PIX_W-1:0] pix_q;
	logic [SUM_W-1:0]           lo_q;
	logic [SUM_W-1:0]           hi_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= pix_in;
			lo_q  <= lo_in;
			hi_q  <= hi_in;
		end
	end

	assign pix_out = pix_q;
	assign lo_out  = lo_q;
	assign hi_out  = hi_q;

endmodule

`default_nettype wire

>>> hdl/laplacian_edge_filter.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter: streaming 3x3 / 5x5 / 7x7 Laplacian edge filter
// Takes grey pixels in raster order, keeps MAX_KERNEL-1 lines in RAM and a
// square window in a row of column cells, and emits one result per interior
// pixel with the signed sum, a clamped copy, the centre position and a
// last-of-frame mark.
// ----------------------------------------------------------------------------
//
//  channel   signals                          handshake
//  -------   -------------------------------  ----------------------------
//  pixel     pixel                            pix_valid / pix_stall
//  result    response clamped center_row      res_valid / res_stall
//            center_col frame_last
//  config    cfg_index cfg_data               cfg_valid / cfg_ready
//
//  One pixel request is taken every clock while pix_stall is low; a result
//  passes in order through the line RAM read at the taking edge, the window
//  shift, the window sum and the output register.
//  The line RAM is not cleared after reset: a result only uses pixels of
//  the current frame, which are always written before they are read.
//  A stalled result holds the stages behind it; empty stages still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_edge_filter #(
	parameter int MAX_LINE   = 2048,
	parameter int MAX_KERNEL = 7
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pix_valid,
	output logic                                   pix_stall,
	input  wire logic [lef_pkg::PIX_W-1:0]         pixel,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic signed [lef_pkg::RESP_W-1:0]      response,
	output logic      [lef_pkg::PIX_W-1:0]         clamped,
	output logic      [lef_pkg::FH_W-1:0]          center_row,
	output logic      [lef_pkg::CCOL_W-1:0]        center_col,
	output logic                                   frame_last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lef_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [lef_pkg::DATA_W-1:0]        cfg_data
);

	import lef_pkg::*;

	localparam int MK      = MAX_KERNEL;
	localparam int RING    = MK - 1;
	localparam int SLOT_W  = $clog2(RING);
	localparam int COL_W   = $clog2(MAX_LINE);
	localparam int WE_W    = COL_W + 1;
	localparam int CC_W    = (COL_W > CCOL_W) ? COL_W : CCOL_W;
	localparam int LO_ROWS = (MK < 5) ? MK : 5;
	localparam int CR3     = MK - 2;
	localparam int CR5     = (MK >= 5) ? MK - 3 : 0;
	localparam int CR7     = (MK >= 7) ? MK - 4 : 0;

	// Configuration registers and frame position.
	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [MODE_W-1:0] kernel_mode_q;
	logic [COL_W-1:0]  col_q;
	logic [FH_W-1:0]   row_q;
	logic [SLOT_W-1:0] slot_q;

	logic              cfg_wr;
	logic              restart;
	logic [WE_W-1:0]   weff;
	logic [FH_W:0]     heff;
	logic              col_end;
	logic              row_end;
	ksel_t             ksel;
	int                half;

	// Stage enables.
	logic ld_out, ld3, ld2, ld1, accept, move1;

	// Stage 1: line RAM read data and column build.
	logic                       valid_s1;
	logic [PIX_W-1:0]           px_s1;
	logic [SLOT_W-1:0]          slot_s1;
	logic                       emit_s1;
	logic [FH_W-1:0]            crow_s1;
	logic [CCOL_W-1:0]          ccol_s1;
	logic                       last_s1;
	logic [PIX_W-1:0]           rd_data [RING];
	logic [MK-1:0][PIX_W-1:0]   col_vec;
	logic [SUM_W-1:0]           col_lo;
	logic [SUM_W-1:0]           col_hi;

	// Stage 2: window is current.
	logic                       valid_s2;
	logic [FH_W-1:0]            crow_s2;
	logic [CCOL_W-1:0]          ccol_s2;
	logic                       last_s2;
	logic [MK-1:0][MK-1:0][PIX_W-1:0] win_pix;
	logic [MK-1:0][SUM_W-1:0]   win_lo;
	logic [MK-1:0][SUM_W-1:0]   win_hi;
	logic [PIX_W-1:0]           centre;
	logic [WSUM_W-1:0]          a_c;
	logic [WSUM_W-1:0]          b_c;

	// Stage 3: subtract and clamp.
	logic                       valid_s3;
	logic [WSUM_W-1:0]          a_s3;
	logic [WSUM_W-1:0]          b_s3;
	logic [FH_W-1:0]            crow_s3;
	logic [CCOL_W-1:0]          ccol_s3;
	logic                       last_s3;
	logic signed [RESP_W-1:0]   resp_c;
	logic [PIX_W-1:0]           clamp_c;

	// Output register.
	logic                       res_valid_q;
	logic signed [RESP_W-1:0]   response_q;
	logic [PIX_W-1:0]           clamped_q;
	logic [FH_W-1:0]            center_row_q;
	logic [CCOL_W-1:0]          center_col_q;
	logic                       frame_last_q;

	// Stage 0 results.
	logic                       emit0;
	logic                       last0;
	logic [FH_W-1:0]            crow0;
	logic [CC_W-1:0]            ccol_full;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == REG_FRAME_WIDTH ||
	                              cfg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			kernel_mode_q  <= RST_KERNEL_MODE;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_KERNEL_MODE:  kernel_mode_q  <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			weff = WE_W'(1);
		end else if (int'(frame_width_q) > MAX_LINE) begin
			weff = WE_W'(MAX_LINE);
		end else begin
			weff = WE_W'(frame_width_q);
		end
		heff = (frame_height_q == '0) ? (FH_W+1)'(1) : {1'b0, frame_height_q};
	end

	assign col_end = ({1'b0, col_q} + WE_W'(1)) >= weff;
	assign row_end = ({1'b0, row_q} + (FH_W+1)'(1)) >= heff;
	assign ksel    = kernel_sel(kernel_mode_q, MK);
	assign half    = kernel_half(ksel);

	assign emit0     = (int'(row_q) >= 2 * half) && (int'(col_q) >= 2 * half);
	assign last0     = row_end && col_end;
	assign crow0     = row_q - FH_W'(half);
	assign ccol_full = CC_W'(col_q) - CC_W'(half);

	// Stage enables: each stage loads when it is empty or its content moves on.
	assign ld_out    = !res_valid_q || !res_stall;
	assign ld3       = !valid_s3 || ld_out;
	assign ld2       = !valid_s2 || ld3;
	assign ld1       = !valid_s1 || ld2;
	assign pix_stall = !ld1;
	assign accept    = pix_valid && ld1;
	assign move1     = valid_s1 && ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + FH_W'(1);
					slot_q <= (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line store: one RAM per stored line, all read at the current column.
	for (genvar i = 0; i < RING; i++) begin : g_line
		lef_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_LINE)
		) u_line (
			.clk   (clk),
			.we    (accept && slot_q == SLOT_W'(i)),
			.waddr (col_q),
			.wdata (pixel),
			.re    (accept),
			.raddr (col_q),
			.rdata (rd_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			slot_s1 <= slot_q;
			emit_s1 <= emit0;
			crow_s1 <= crow0;
			ccol_s1 <= ccol_full[CCOL_W-1:0];
			last_s1 <= last0;
		end
	end

	// Window row r takes the line that is MK-1-r rows above the new pixel.
	always_comb begin
		int idx;
		idx = 0;
		col_lo = '0;
		col_hi = '0;
		for (int r = 0; r < MK; r++) begin
			if (r == MK - 1) begin
				col_vec[r] = px_s1;
			end else begin
				idx = int'(slot_s1) + r;
				if (idx >= RING) begin
					idx = idx - RING;
				end
				col_vec[r] = rd_data[SLOT_W'(idx)];
			end
			col_hi = col_hi + SUM_W'(col_vec[r]);
			if (r >= MK - LO_ROWS) begin
				col_lo = col_lo + SUM_W'(col_vec[r]);
			end
		end
	end

	for (genvar c = 0; c < MK; c++) begin : g_cell
		if (c == MK - 1) begin : g_head
			lef_cell #(
				.ROWS(MK)
			) u_cell (
				.clk     (clk),
				.shift   (move1),
				.pix_in  (col_vec),
				.lo_in   (col_lo),
				.hi_in   (col_hi),
				.pix_out (win_pix[c]),
				.lo_out  (win_lo[c]),
				.hi_out  (win_hi[c])
			);
		end else begin : g_body
			lef_cell #(
				.ROWS(MK)
			) u_cell (
				.clk     (clk),
				.shift   (move1),
				.pix_in  (win_pix[c+1]),
				.lo_in   (win_lo[c+1]),
				.hi_in   (win_hi[c+1]),
				.pix_out (win_pix[c]),
				.lo_out  (win_lo[c]),
				.hi_out  (win_hi[c])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ld2) begin
			valid_s2 <= move1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			last_s2 <= last_s1;
		end
	end

	// The window is indexed as win_pix[column][row].
	always_comb begin
		logic [WSUM_W-1:0] tot;
		tot = '0;
		case (ksel)
			KS_5: begin
				centre = win_pix[CR5][CR5];
				for (int c = 0; c < MK; c++) begin
					if (c >= MK - 5) begin
						tot = tot + WSUM_W'(win_lo[c]);
					end
				end
				a_c = WSUM_W'(centre) * WSUM_W'(W_5 + 1);
				b_c = tot;
			end
			KS_7: begin
				centre = win_pix[CR7][CR7];
				for (int c = 0; c < MK; c++) begin
					tot = tot + WSUM_W'(win_hi[c]);
				end
				a_c = WSUM_W'(centre) * WSUM_W'(W_7 + 1);
				b_c = tot;
			end
			default: begin
				centre = win_pix[CR3][CR3];
				a_c = WSUM_W'(centre) * WSUM_W'(W_CROSS);
				b_c = WSUM_W'(win_pix[CR3][CR3-1]) + WSUM_W'(win_pix[CR3][CR3+1])
				    + WSUM_W'(win_pix[CR3-1][CR3]) + WSUM_W'(win_pix[CR3+1][CR3]);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ld3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ld3) begin
			a_s3    <= a_c;
			b_s3    <= b_c;
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		resp_c = $signed({1'b0, a_s3}) - $signed({1'b0, b_s3});
		if (resp_c < 0) begin
			clamp_c = '0;
		end else if (resp_c > RESP_W'(PIX_MAX)) begin
			clamp_c = PIX_W'(PIX_MAX);
		end else begin
			clamp_c = resp_c[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_out) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ld_out) begin
			response_q   <= resp_c;
			clamped_q    <= clamp_c;
			center_row_q <= crow_s3;
			center_col_q <= ccol_s3;
			frame_last_q <= last_s3;
		end
	end

	assign res_valid  = res_valid_q;
	assign response   = response_q;
	assign clamped    = clamped_q;
	assign center_row = center_row_q;
	assign center_col = center_col_q;
	assign frame_last = frame_last_q;

endmodule

`default_nettype wire
